// ===== hw/rtl/generational_handle_table_top_macros.svh =====
// Assertion macros for the handle table top module.
// Unless ASSERT_OFF is defined, each macro expands to one labeled concurrent
// assertion clocked on i_clk and disabled while i_rst_n is low.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define GHT_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`define GHT_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define GHT_ASSERT_IMP(lbl, pre, post, msg)

`define GHT_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

// ===== hw/rtl/ght_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

    localparam int MODE_W   = 3;
    localparam int IDX_W    = 8;
    localparam int VER_W    = 32;
    localparam int COMP_W   = 5;
    localparam int STATUS_W = 2;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_ALLOC = 3'd0;
    localparam t_mode MODE_FREE  = 3'd1;
    localparam t_mode MODE_SET   = 3'd2;
    localparam t_mode MODE_CLR   = 3'd3;
    localparam t_mode MODE_TEST  = 3'd4;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_BAD  = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    // Outcome of one handle operation, handed from the slot unit to the sequencer.
    typedef struct packed {
        t_status status;
        logic    has;
        logic    wr_entry;
        logic    push_free;
    } t_slot_op;

endpackage

`default_nettype wire

// ===== hw/rtl/generational_handle_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generational handle table. A request either allocates a handle (slot index
// plus version) or acts on an existing handle: free it, set, clear or test one
// component bit. Every handle is checked for range, liveness and an exact
// version match; a failed check answers status 1 and leaves the table alone,
// and an allocate with no free or fresh slot left answers status 2. Freed
// slots sit on a last-in first-out stack and are reused before fresh ones,
// keeping the version that the free bumped. One item yields exactly one
// result item. Items are handled one at a time: a handle request or an
// allocate of a fresh slot is accepted with the slot memory read, then
// written back with its result, while an allocate that pops the free stack
// reads the slot in a step of its own between the two, since the slot address
// comes out of the stack memory first. Both memories have registered reads. A
// new item is accepted while the previous result still waits in the output
// register, and write back stalls only while that register is full. No
// clearing pass follows reset: a slot counts as live only below the count of
// fresh slots handed out, so the memories need no initialization.
`include "generational_handle_table_top_macros.svh"

module generational_handle_table_top #(
    parameter int MAX_ENTITIES   = 256,
    parameter int MAX_COMPONENTS = 32,
    parameter int VERSION_BITS   = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [ght_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [ght_pkg::IDX_W-1:0]    i_entity_index,
    input  wire logic [ght_pkg::VER_W-1:0]    i_entity_version,
    input  wire logic [ght_pkg::COMP_W-1:0]   i_component_id,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [ght_pkg::STATUS_W-1:0]      o_status,
    output logic [ght_pkg::IDX_W-1:0]         o_out_index,
    output logic [ght_pkg::VER_W-1:0]         o_out_version,
    output logic                              o_has_component
);

    import ght_pkg::*;

    localparam int IW    = $clog2(MAX_ENTITIES);
    localparam int CNT_W = IW + 1;
    localparam int EW    = 1 + VERSION_BITS + MAX_COMPONENTS;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STK  = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]  r_used_cnt, n_used_cnt;
    logic              r_out_valid, n_out_valid;

    // Request held while it is worked on.
    t_mode             r_mode;
    logic [IDX_W-1:0]  r_idx;
    logic [VER_W-1:0]  r_ver;
    logic [COMP_W-1:0] r_comp;
    logic [IW-1:0]     r_slot, n_slot;

    // Result register.
    t_status           r_status, n_status;
    logic [IDX_W-1:0]  r_out_index, n_out_index;
    logic [VER_W-1:0]  r_out_version, n_out_version;
    logic              r_has, n_has;

    logic              in_fire;
    logic              out_free;
    logic [CNT_W-1:0]  stk_top;

    // Slot memory: each word is {live, version, component mask}.
    logic              slot_we, slot_re;
    logic [IW-1:0]     slot_waddr, slot_raddr;
    logic [EW-1:0]     slot_wdata, slot_rdata;

    // Free stack memory.
    logic              stk_we, stk_re;
    logic [IW-1:0]     stk_waddr, stk_raddr;
    logic [IW-1:0]     stk_wdata, stk_rdata;

    logic                      rd_live;
    logic [VERSION_BITS-1:0]   rd_ver;
    logic [MAX_COMPONENTS-1:0] rd_mask;

    t_slot_op                  alu_op;
    logic                      alu_live;
    logic [VERSION_BITS-1:0]   alu_ver;
    logic [MAX_COMPONENTS-1:0] alu_mask;

    logic alloc_pop, alloc_fresh;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign stk_top    = r_free_cnt - CNT_W'(1);

    assign {rd_live, rd_ver, rd_mask} = slot_rdata;

    // Counts are only changed at write back, so the choice made when the
    // item was accepted still holds here.
    assign alloc_pop   = (r_free_cnt != '0);
    assign alloc_fresh = !alloc_pop && (r_used_cnt < CNT_W'(MAX_ENTITIES));

    ght_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTITIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    ght_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ENTITIES)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    ght_slot_alu #(
        .MAX_ENTITIES   (MAX_ENTITIES),
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .VERSION_BITS   (VERSION_BITS),
        .CNT_W          (CNT_W)
    ) u_slot_alu (
        .i_mode      (r_mode),
        .i_idx       (r_idx),
        .i_ver       (r_ver),
        .i_comp      (r_comp),
        .i_used_cnt  (r_used_cnt),
        .i_free_cnt  (r_free_cnt),
        .i_live      (rd_live),
        .i_slot_ver  (rd_ver),
        .i_slot_mask (rd_mask),
        .o_op        (alu_op),
        .o_live      (alu_live),
        .o_ver       (alu_ver),
        .o_mask      (alu_mask)
    );

    always_comb begin
        n_state       = r_state;
        n_free_cnt    = r_free_cnt;
        n_used_cnt    = r_used_cnt;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_slot        = r_slot;
        n_status      = r_status;
        n_out_index   = r_out_index;
        n_out_version = r_out_version;
        n_has         = r_has;

        slot_re    = 1'b0;
        slot_raddr = IW'(i_entity_index);
        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = {alu_live, alu_ver, alu_mask};
        stk_re     = 1'b0;
        stk_raddr  = stk_top[IW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_free_cnt[IW-1:0];
        stk_wdata  = r_slot;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // Read the addressed slot right away; an allocate that
                    // will pop reads the stack top instead of using it.
                    slot_re = 1'b1;
                    stk_re  = 1'b1;
                    n_slot  = IW'(i_entity_index);
                    if (i_mode == MODE_ALLOC && r_free_cnt != '0) begin
                        n_state = S_STK;
                    end else begin
                        n_state = S_WB;
                    end
                end
            end
            S_STK: begin
                slot_re    = 1'b1;
                slot_raddr = stk_rdata;
                n_slot     = stk_rdata;
                n_state    = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_index   = '0;
                    n_out_version = '0;
                    n_has         = 1'b0;
                    if (r_mode == MODE_ALLOC) begin
                        if (alloc_pop) begin
                            // Reused slot keeps its stored version.
                            slot_we       = 1'b1;
                            slot_wdata    = {1'b1, rd_ver, {MAX_COMPONENTS{1'b0}}};
                            n_free_cnt    = stk_top;
                            n_status      = ST_OK;
                            n_out_index   = IDX_W'(r_slot);
                            n_out_version = VER_W'(rd_ver);
                        end else if (alloc_fresh) begin
                            slot_we       = 1'b1;
                            slot_waddr    = r_used_cnt[IW-1:0];
                            slot_wdata    = {1'b1, {(EW-1){1'b0}}};
                            n_used_cnt    = r_used_cnt + CNT_W'(1);
                            n_status      = ST_OK;
                            n_out_index   = IDX_W'(r_used_cnt[IW-1:0]);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else begin
                        slot_we  = alu_op.wr_entry;
                        stk_we   = alu_op.push_free;
                        n_status = alu_op.status;
                        n_has    = alu_op.has;
                        if (alu_op.push_free) begin
                            n_free_cnt = r_free_cnt + CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_cnt  <= '0;
            r_used_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_cnt  <= n_free_cnt;
            r_used_cnt  <= n_used_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= i_mode;
            r_idx  <= i_entity_index;
            r_ver  <= i_entity_version;
            r_comp <= i_component_id;
        end
        r_slot        <= n_slot;
        r_status      <= n_status;
        r_out_index   <= n_out_index;
        r_out_version <= n_out_version;
        r_has         <= n_has;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_out_index     = r_out_index;
    assign o_out_version   = r_out_version;
    assign o_has_component = r_has;

    // Every slot on the free stack was once handed out fresh.
    `GHT_ASSERT_IMP(a_free_le_used, 1'b1, r_free_cnt <= r_used_cnt, "free count above used count")

    // The fresh count never runs past the table size.
    `GHT_ASSERT_IMP(a_used_bound, 1'b1, r_used_cnt <= CNT_W'(MAX_ENTITIES), "used count overflow")

    // An accepted item always moves the sequencer out of the idle state.
    `GHT_ASSERT_NXT(a_busy_after_accept, in_fire, r_state != S_IDLE, "accepted item not worked on")

    // A result is only produced out of the write back state.
    `GHT_ASSERT_NXT(a_result_from_wb, r_state != S_WB && !(r_out_valid && !i_out_ready), !r_out_valid, "result without write back")

endmodule

`default_nettype wire

// ===== hw/rtl/ght_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ght_slot_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ght_slot_alu #(
    parameter int MAX_ENTITIES   = 256,
    parameter int MAX_COMPONENTS = 32,
    parameter int VERSION_BITS   = 32,
    parameter int CNT_W          = 9
) (
    input  wire logic [ght_pkg::MODE_W-1:0] i_mode,
    input  wire logic [ght_pkg::IDX_W-1:0]  i_idx,
    input  wire logic [ght_pkg::VER_W-1:0]  i_ver,
    input  wire logic [ght_pkg::COMP_W-1:0] i_comp,
    input  wire logic [CNT_W-1:0]           i_used_cnt,
    input  wire logic [CNT_W-1:0]           i_free_cnt,
    input  wire logic                       i_live,
    input  wire logic [VERSION_BITS-1:0]    i_slot_ver,
    input  wire logic [MAX_COMPONENTS-1:0]  i_slot_mask,
    output ght_pkg::t_slot_op               o_op,
    output logic                            o_live,
    output logic [VERSION_BITS-1:0]         o_ver,
    output logic [MAX_COMPONENTS-1:0]       o_mask
);

    import ght_pkg::*;

    logic [16:0]               idx_ext;
    logic                      handle_ok;
    logic                      comp_ok;
    logic [MAX_COMPONENTS-1:0] sel;

    // Slots at or above the fresh count were never handed out, so their
    // memory words are not trusted and the slot counts as not live.
    assign idx_ext   = 17'(i_idx);
    assign handle_ok = (idx_ext < 17'(MAX_ENTITIES)) && (idx_ext < 17'(i_used_cnt))
                       && i_live && (VER_W'(i_slot_ver) == i_ver);
    assign comp_ok   = 7'(i_comp) < 7'(MAX_COMPONENTS);
    assign sel       = MAX_COMPONENTS'(1) << i_comp;

    always_comb begin
        o_op        = '0;
        o_op.status = ST_OK;
        o_live      = i_live;
        o_ver       = i_slot_ver;
        o_mask      = i_slot_mask;
        case (i_mode)
            MODE_FREE: begin
                if (!handle_ok) begin
                    o_op.status = ST_BAD;
                end else begin
                    o_op.wr_entry  = 1'b1;
                    o_op.push_free = i_free_cnt < CNT_W'(MAX_ENTITIES);
                    o_live         = 1'b0;
                    o_ver          = i_slot_ver + VERSION_BITS'(1);
                    o_mask         = '0;
                end
            end
            MODE_SET: begin
                if (!handle_ok || !comp_ok) begin
                    o_op.status = ST_BAD;
                end else begin
                    o_op.wr_entry = 1'b1;
                    o_mask        = i_slot_mask | sel;
                end
            end
            MODE_CLR: begin
                if (!handle_ok || !comp_ok) begin
                    o_op.status = ST_BAD;
                end else begin
                    o_op.wr_entry = 1'b1;
                    o_mask        = i_slot_mask & ~sel;
                end
            end
            MODE_TEST: begin
                if (!handle_ok || !comp_ok) begin
                    o_op.status = ST_BAD;
                end else begin
                    o_op.has = |(i_slot_mask & sel);
                end
            end
            default: begin
                o_op.status = ST_BAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_generational_handle_table_top.sv =====
`timescale 1ns / 1ps

module tb_generational_handle_table_top;

    import ght_pkg::*;

    localparam int NUM_SLOTS       = 256;
    localparam int ITEMS_PER_PHASE = 312;
    localparam int NUM_PHASES      = 4;
    localparam int NUM_ROWS        = 26;

    // One result item as the block presents it.
    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    index;
        logic [VER_W-1:0]    version;
        logic                has;
    } t_result;

    // One row of the directed table. Rows with typed set carry their answer
    // written out by hand; the others are checked against the predictor.
    typedef struct packed {
        logic                typed;
        t_mode               mode;
        logic [IDX_W-1:0]    idx;
        logic [VER_W-1:0]    ver;
        logic [COMP_W-1:0]   comp;
        t_result             res;
    } t_row;

    localparam t_result NO_RESULT = '{ST_OK, 8'd0, 32'd0, 1'b0};

    // Walk through the basic life of a handle: fresh allocation, component
    // bits at both ends of the range, stale and mangled versions, unknown
    // modes, double free, reuse with the bumped version, and the last-in
    // first-out order of the free stack ahead of fresh slots.
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{1'b1, MODE_ALLOC, 8'd0, 32'd0,          5'd0,  '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_ALLOC, 8'd0, 32'hFFFF_FFFF,  5'd31, '{ST_OK,  8'd1, 32'd0, 1'b0}},
        '{1'b1, MODE_SET,   8'd0, 32'd0,          5'd31, '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_TEST,  8'd0, 32'd0,          5'd31, '{ST_OK,  8'd0, 32'd0, 1'b1}},
        '{1'b1, MODE_TEST,  8'd0, 32'd0,          5'd0,  '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_SET,   8'd1, 32'd0,          5'd0,  '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_CLR,   8'd0, 32'd0,          5'd31, '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_TEST,  8'd0, 32'd0,          5'd31, '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b0, MODE_TEST,  8'd1, 32'd0,          5'd0,  NO_RESULT},
        '{1'b1, MODE_FREE,  8'd1, 32'd1,          5'd0,  '{ST_BAD, 8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_FREE,  8'd1, 32'hFFFF_FFFF,  5'd0,  '{ST_BAD, 8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_SET,   8'd0, 32'h8000_0000,  5'd5,  '{ST_BAD, 8'd0, 32'd0, 1'b0}},
        '{1'b1, 3'(MODE_TEST + 3'd1), 8'd0, 32'd0, 5'd0, '{ST_BAD, 8'd0, 32'd0, 1'b0}},
        '{1'b1, 3'(MODE_TEST + 3'd2), 8'd0, 32'd0, 5'd0, '{ST_BAD, 8'd0, 32'd0, 1'b0}},
        '{1'b1, 3'(MODE_TEST + 3'd3), 8'd0, 32'd0, 5'd31, '{ST_BAD, 8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_FREE,  8'd0, 32'd0,          5'd0,  '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_TEST,  8'd0, 32'd0,          5'd0,  '{ST_BAD, 8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_FREE,  8'd0, 32'd0,          5'd0,  '{ST_BAD, 8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_ALLOC, 8'd1, 32'd0,          5'd0,  '{ST_OK,  8'd0, 32'd1, 1'b0}},
        '{1'b1, MODE_TEST,  8'd0, 32'd1,          5'd31, '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_FREE,  8'd1, 32'd0,          5'd0,  '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_FREE,  8'd0, 32'd1,          5'd0,  '{ST_OK,  8'd0, 32'd0, 1'b0}},
        '{1'b1, MODE_ALLOC, 8'd0, 32'd0,          5'd0,  '{ST_OK,  8'd0, 32'd2, 1'b0}},
        '{1'b1, MODE_ALLOC, 8'd0, 32'd0,          5'd0,  '{ST_OK,  8'd1, 32'd1, 1'b0}},
        '{1'b1, MODE_ALLOC, 8'd0, 32'd0,          5'd0,  '{ST_OK,  8'd2, 32'd0, 1'b0}},
        '{1'b0, MODE_TEST,  8'd1, 32'd1,          5'd0,  NO_RESULT}
    };

    // Per phase: chance of an allocate and of a free, in percent. The second
    // phase fills the table until allocation runs into the full case, the
    // third drains it again through the free stack.
    localparam int ALLOC_PCT [NUM_PHASES] = '{35, 90, 15, 40};
    localparam int FREE_PCT  [NUM_PHASES] = '{20,  2, 45, 20};
    localparam int SEND_IDLE [NUM_PHASES] = '{ 0, 47,  0, 21};
    localparam int RECV_IDLE [NUM_PHASES] = '{ 0,  0, 47, 21};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_mode                i_mode = MODE_ALLOC;
    logic [IDX_W-1:0]     i_entity_index = '0;
    logic [VER_W-1:0]     i_entity_version = '0;
    logic [COMP_W-1:0]    i_component_id = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_status              o_status;
    logic [IDX_W-1:0]     o_out_index;
    logic [VER_W-1:0]     o_out_version;
    logic                 o_has_component;

    // Shadow copy of the handle table, updated in the order items are accepted.
    bit [VER_W-1:0]       slot_ver [NUM_SLOTS];
    bit                   slot_alive [NUM_SLOTS];
    bit [31:0]            slot_bits [NUM_SLOTS];
    bit [IDX_W-1:0]       freed_slots [NUM_SLOTS];
    int                   freed_depth = 0;
    int                   fresh_used = 0;

    t_result              pending_results [$];
    int                   mismatch_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    generational_handle_table_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_entity_index   (i_entity_index),
        .i_entity_version (i_entity_version),
        .i_component_id   (i_component_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_out_index      (o_out_index),
        .o_out_version    (o_out_version),
        .o_has_component  (o_has_component)
    );

    // Computes the answer to one request and applies its effect to the shadow
    // table. Handle checks cover the mode, liveness and version; no range check
    // is made, since it cannot fail with an 8-bit index over 256 slots, and
    // neither can the component range check with 32 component bits.
    function automatic t_result predict_handle_op(input t_mode m, input logic [IDX_W-1:0] idx,
                                                  input logic [VER_W-1:0] ver,
                                                  input logic [COMP_W-1:0] comp);
        t_result          r;
        logic [IDX_W-1:0] slot;
        r = NO_RESULT;
        slot = '0;
        if (m == MODE_ALLOC) begin
            if (freed_depth > 0) begin
                // Reused slots keep the version that the free bumped.
                freed_depth--;
                slot = freed_slots[freed_depth];
            end else if (fresh_used < NUM_SLOTS) begin
                slot = IDX_W'(fresh_used);
                fresh_used++;
                slot_ver[slot] = '0;
            end else begin
                r.status = ST_FULL;
            end
            if (r.status == ST_OK) begin
                slot_alive[slot] = 1'b1;
                slot_bits[slot] = '0;
                r.index = slot;
                r.version = slot_ver[slot];
            end
        end else if (m > MODE_TEST || !slot_alive[idx] || slot_ver[idx] != ver) begin
            r.status = ST_BAD;
        end else if (m == MODE_FREE) begin
            slot_ver[idx] = slot_ver[idx] + 1'b1;
            slot_bits[idx] = '0;
            slot_alive[idx] = 1'b0;
            freed_slots[freed_depth] = idx;
            freed_depth++;
        end else if (m == MODE_SET) begin
            slot_bits[idx][comp] = 1'b1;
        end else if (m == MODE_CLR) begin
            slot_bits[idx][comp] = 1'b0;
        end else begin
            r.has = slot_bits[idx][comp];
        end
        return r;
    endfunction

    function automatic int pick_live_slot();
        int live_list [$];
        for (int i = 0; i < fresh_used; i++) begin
            if (slot_alive[i]) begin
                live_list.insert(live_list.size(), i);
            end
        end
        if (live_list.size() == 0) begin
            return -1;
        end
        return live_list[$urandom_range(live_list.size() - 1)];
    endfunction

    // Any slot that has been handed out at least once, or slot 0 while none has
    // been. Random requests never name a slot that was never allocated, so the
    // slot memory is never read for them at an entry that holds no data yet.
    function automatic logic [IDX_W-1:0] pick_known_slot();
        if (fresh_used == 0) begin
            return '0;
        end
        return IDX_W'($urandom_range(fresh_used - 1));
    endfunction

    // Presents one item and holds it until accepted. The valid line is only
    // lowered for an idle gap, so back-to-back items keep it high and each
    // edge sees at most one assignment to it.
    task automatic send_request(input t_mode m, input logic [IDX_W-1:0] idx,
                                input logic [VER_W-1:0] ver, input logic [COMP_W-1:0] comp,
                                input logic typed, input t_result typed_res);
        t_result want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_mode           <= m;
        i_entity_index   <= idx;
        i_entity_version <= ver;
        i_component_id   <= comp;
        do @(posedge i_clk); while (!o_in_ready);
        want = predict_handle_op(m, idx, ver, comp);
        pending_results.insert(pending_results.size(), typed ? typed_res : want);
    endtask

    // Builds one random request. Most traffic uses live handles with their
    // correct version; up to a tenth is stale versions, slots that may be dead and
    // unknown modes.
    task automatic send_random_request(input int alloc_pct, input int free_pct);
        int                roll;
        int                live;
        t_mode             m;
        logic [IDX_W-1:0]  idx;
        logic [VER_W-1:0]  ver;
        logic [COMP_W-1:0] comp;
        roll = $urandom_range(99);
        live = pick_live_slot();
        comp = COMP_W'($urandom_range(31));
        idx = pick_known_slot();
        ver = $urandom;
        m = MODE_ALLOC;
        if (fresh_used == 0 || roll < alloc_pct || live < 0) begin
            m = MODE_ALLOC;
        end else if (roll < alloc_pct + free_pct) begin
            m = MODE_FREE;
            idx = IDX_W'(live);
            ver = slot_ver[idx];
        end else if (roll < 90) begin
            idx = IDX_W'(live);
            ver = slot_ver[idx];
            case ($urandom_range(2))
                0: m = MODE_SET;
                1: m = MODE_CLR;
                default: m = MODE_TEST;
            endcase
        end else begin
            m = t_mode'($urandom_range(int'(MODE_FREE), int'(MODE_TEST)));
            case ($urandom_range(3))
                0: begin
                    // Live handle with one version bit flipped.
                    idx = IDX_W'(live);
                    ver = slot_ver[idx] ^ (VER_W'(1) << $urandom_range(VER_W - 1));
                end
                1: begin
                    // Any known slot, random version.
                end
                2: begin
                    // Known slot with its current version: live or freed.
                    ver = slot_ver[idx];
                end
                default: begin
                    idx = IDX_W'(live);
                    ver = slot_ver[idx];
                    m = t_mode'($urandom_range(int'(MODE_TEST) + 1, (1 << MODE_W) - 1));
                end
            endcase
        end
        send_request(m, idx, ver, comp, 1'b0, NO_RESULT);
    endtask

    // Holds the sender off until every result in flight has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Result side: random back-pressure and an in-order check of every
    // accepted result against the oldest outstanding expectation.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_status, o_out_index, o_out_version, o_has_component};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result with nothing pending:", $realtime,
                             " status %0d index %0d ver %0h has %0d",
                             got.status, got.index, got.version, got.has);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.index !== want.index ||
                    got.version !== want.version || got.has !== want.has) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: mismatch: expected status %0d index %0d ver %0h has %0d,",
                                 $realtime, want.status, want.index, want.version, want.has,
                                 " got status %0d index %0d ver %0h has %0d",
                                 got.status, got.index, got.version, got.has);
                    end
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_request(DIRECTED[r].mode, DIRECTED[r].idx, DIRECTED[r].ver,
                         DIRECTED[r].comp, DIRECTED[r].typed, DIRECTED[r].res);
        end
        wait_for_results();

        // Each phase changes the traffic mix and the idling pattern, and
        // lets the block run empty before the next one starts.
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_IDLE[p];
            repeat (ITEMS_PER_PHASE) begin
                send_random_request(ALLOC_PCT[p], FREE_PCT[p]);
            end
            wait_for_results();
        end

        // Idle on before the verdict so that a stray extra result would still show up.
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Ends the run as failed if it hangs.
    initial begin : watchdog
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
